// File: rtl/core/rvimm_pkg.sv
package rvimm_pkg;

    // Architectural widths and default register count.
    localparam int XLEN              = 64;
    localparam int REG_COUNT_DEFAULT = 32;

    // Command codes carried by a request.
    typedef enum logic [1:0] {
        CMD_EXEC  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    // OP-IMM funct3 encodings.
    typedef enum logic [2:0] {
        F3_ADDI  = 3'd0,
        F3_SLLI  = 3'd1,
        F3_SLTI  = 3'd2,
        F3_SLTIU = 3'd3,
        F3_XORI  = 3'd4,
        F3_SRXI  = 3'd5,
        F3_ORI   = 3'd6,
        F3_ANDI  = 3'd7
    } funct3_t;

    // funct6 encodings that make the shift-right group legal.
    localparam logic [5:0] F6_SRLI = 6'h00;
    localparam logic [5:0] F6_SRAI = 6'h10;

    // Request payload.
    typedef struct packed {
        cmd_t              cmd;
        logic [31:0]       instruction_word;
        logic [4:0]        reg_index;
        logic [XLEN-1:0]   reg_value;
    } req_t;

    // Result payload.
    typedef struct packed {
        logic [XLEN-1:0]   value;
        logic [4:0]        dest_index;
        logic              wrote;
        logic              illegal;
    } rsp_t;

    // Register file write port.
    typedef struct packed {
        logic              en;
        logic [4:0]        index;
        logic [XLEN-1:0]   data;
    } wr_t;

    // True when the index names a real, writable register (not x0, below the count).
    function automatic logic reg_in_range(logic [4:0] idx, logic [5:0] limit);
        return (idx != 5'd0) && ({1'b0, idx} < limit);
    endfunction

endpackage

// File: rtl/core/rvimm_chan_if.sv
interface rvimm_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/core/rvimm_regfile.sv
module rvimm_regfile #(
    parameter int REG_COUNT = rvimm_pkg::REG_COUNT_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [4:0]                  rd_index,
    output logic [rvimm_pkg::XLEN-1:0]  rd_data,
    input  rvimm_pkg::wr_t              wr
);

    localparam int         IDX_W     = $clog2(REG_COUNT);
    localparam logic [5:0] REG_LIMIT = 6'(REG_COUNT);

    logic [rvimm_pkg::XLEN-1:0] mem_reg [REG_COUNT];

    // Storage: cleared by reset, written one entry per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
            begin
                mem_reg[i] <= '0;
            end
        end
        else if (wr.en)
        begin
            mem_reg[wr.index[IDX_W-1:0]] <= wr.data;
        end
    end

    // Read port: x0 and indices beyond the file read as zero.
    always_comb
    begin
        if (rvimm_pkg::reg_in_range(rd_index, REG_LIMIT))
        begin
            rd_data = mem_reg[rd_index[IDX_W-1:0]];
        end
        else
        begin
            rd_data = '0;
        end
    end

endmodule

// File: rtl/core/rvimm_alu.sv
module rvimm_alu #(
    parameter int REG_COUNT = rvimm_pkg::REG_COUNT_DEFAULT
) (
    input  rvimm_pkg::req_t             req,
    output logic [4:0]                  rd_index,
    input  logic [rvimm_pkg::XLEN-1:0]  rd_data,
    output rvimm_pkg::rsp_t             rsp,
    output rvimm_pkg::wr_t              wr
);

    localparam logic [5:0] REG_LIMIT = 6'(REG_COUNT);

    logic [4:0]                 rd;
    logic [4:0]                 rs1;
    logic [5:0]                 shamt;
    logic [5:0]                 funct6;
    rvimm_pkg::funct3_t         funct3;
    logic [rvimm_pkg::XLEN-1:0] imm;
    logic [rvimm_pkg::XLEN-1:0] exec_value;
    logic                       exec_ok;

    // Instruction field decode.
    assign rd     = req.instruction_word[11:7];
    assign funct3 = rvimm_pkg::funct3_t'(req.instruction_word[14:12]);
    assign rs1    = req.instruction_word[19:15];
    assign shamt  = req.instruction_word[25:20];
    assign funct6 = req.instruction_word[31:26];
    assign imm    = {{(rvimm_pkg::XLEN-12){req.instruction_word[31]}},
                     req.instruction_word[31:20]};

    // The file is read at rs1 for execution and at the given index otherwise.
    assign rd_index = (req.cmd == rvimm_pkg::CMD_EXEC) ? rs1 : req.reg_index;

    // OP-IMM operation.
    always_comb
    begin
        exec_ok    = 1'b1;
        exec_value = '0;
        case (funct3)
            rvimm_pkg::F3_ADDI:  exec_value = rd_data + imm;
            rvimm_pkg::F3_SLLI:  exec_value = rd_data << shamt;
            rvimm_pkg::F3_SLTI:
                exec_value = {63'd0, $signed(rd_data) < $signed(imm)};
            rvimm_pkg::F3_SLTIU: exec_value = {63'd0, rd_data < imm};
            rvimm_pkg::F3_XORI:  exec_value = rd_data ^ imm;
            rvimm_pkg::F3_SRXI:
            begin
                if (funct6 == rvimm_pkg::F6_SRLI)
                begin
                    exec_value = rd_data >> shamt;
                end
                else if (funct6 == rvimm_pkg::F6_SRAI)
                begin
                    exec_value = $unsigned($signed(rd_data) >>> shamt);
                end
                else
                begin
                    exec_ok = 1'b0;
                end
            end
            rvimm_pkg::F3_ORI:   exec_value = rd_data | imm;
            rvimm_pkg::F3_ANDI:  exec_value = rd_data & imm;
            default:             exec_value = '0;
        endcase
    end

    // Result and write request per command.
    always_comb
    begin
        rsp = '0;
        wr  = '0;
        case (req.cmd)
            rvimm_pkg::CMD_EXEC:
            begin
                rsp.value      = exec_value;
                rsp.dest_index = rd;
                rsp.illegal    = ~exec_ok;
                rsp.wrote      = exec_ok && rvimm_pkg::reg_in_range(rd, REG_LIMIT);
                wr.en          = rsp.wrote;
                wr.index       = rd;
                wr.data        = exec_value;
            end
            rvimm_pkg::CMD_WRITE:
            begin
                rsp.value      = req.reg_value;
                rsp.dest_index = req.reg_index;
                rsp.wrote      = rvimm_pkg::reg_in_range(req.reg_index, REG_LIMIT);
                wr.en          = rsp.wrote;
                wr.index       = req.reg_index;
                wr.data        = req.reg_value;
            end
            rvimm_pkg::CMD_READ:
            begin
                rsp.value      = rd_data;
            end
            default:
            begin
                rsp = '0;
            end
        endcase
    end

endmodule

// File: rtl/core/rv64_immediate_alu_execute_unit.sv
// RV64 OP-IMM execute unit with a 64-bit register file.
// A request accepted into the request register passes the ALU into the result register.
// Throughput: one request per cycle while the result side is ready; the register file is
// updated as the result registers, so a following request always sees the previous write.
// Reset clears the register file to zero and empties the request and result registers.
module rv64_immediate_alu_execute_unit #(
    parameter int REG_COUNT = rvimm_pkg::REG_COUNT_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    rvimm_chan_if.sink   req,
    rvimm_chan_if.source rsp
);

    logic                        req_valid_reg;
    logic                        req_valid_next;
    rvimm_pkg::req_t             req_data_reg;
    logic                        rsp_valid_reg;
    logic                        rsp_valid_next;
    rvimm_pkg::rsp_t             rsp_data_reg;
    rvimm_pkg::rsp_t             rsp_data_next;
    rvimm_pkg::wr_t              alu_wr;
    rvimm_pkg::wr_t              file_wr;
    logic [4:0]                  rd_index;
    logic [rvimm_pkg::XLEN-1:0]  rd_data;
    logic                        advance;
    logic                        req_take;

    // Handshake: the request stage moves on when the result register is free or draining.
    assign advance   = req_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign req.ready = !req_valid_reg || advance;
    assign req_take  = req.valid && req.ready;

    assign req_valid_next = req_take || (req_valid_reg && !advance);
    assign rsp_valid_next = advance || (rsp_valid_reg && !rsp.ready);

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            req_data_reg <= req.payload;
        end
        if (advance)
        begin
            rsp_data_reg <= rsp_data_next;
        end
    end

    // The file is written only when the request actually moves into the result register.
    always_comb
    begin
        file_wr    = alu_wr;
        file_wr.en = alu_wr.en && advance;
    end

    rvimm_regfile #(
        .REG_COUNT (REG_COUNT)
    ) u_regfile (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_index (rd_index),
        .rd_data  (rd_data),
        .wr       (file_wr)
    );

    rvimm_alu #(
        .REG_COUNT (REG_COUNT)
    ) u_alu (
        .req      (req_data_reg),
        .rd_index (rd_index),
        .rd_data  (rd_data),
        .rsp      (rsp_data_next),
        .wr       (alu_wr)
    );

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_data_reg;

endmodule
